>>> design/tpss_pkg.sv
// shared types, codes and phase tables for the two-pin stepper sequencer
package tpss_pkg;

    localparam int DRIVE_W  = 25;
    localparam int DEAD_W   = 16;
    localparam int SETTLE_W = 20;
    localparam int TIMER_W  = 25;
    localparam int STEPS_W  = 8;
    localparam int PHASE_W  = 3;
    localparam int ADDR_W   = 4;

    localparam logic [DRIVE_W-1:0]  DRIVE_RST  = 25'd5000;
    localparam logic [DEAD_W-1:0]   DEAD_RST   = 16'd1000;
    localparam logic [SETTLE_W-1:0] SETTLE_RST = 20'd200000;

    localparam logic [PHASE_W-1:0] LAST_PHASE = 3'd7;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_DRIVE  = 2'd0;
    localparam logic [1:0] REG_DEAD   = 2'd1;
    localparam logic [1:0] REG_SETTLE = 2'd2;

    // action codes on the input stream
    localparam logic [1:0] ACT_TICK    = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    typedef enum logic [1:0] {
        PIN_FLOAT = 2'd0,
        PIN_HIGH  = 2'd1,
        PIN_LOW   = 2'd2
    } pin_t;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STEP   = 2'd1,
        MODE_SETTLE = 2'd2
    } mode_t;

    typedef struct packed {
        logic [DRIVE_W-1:0]  drive_ticks;
        logic [DEAD_W-1:0]   dead_ticks;
        logic [SETTLE_W-1:0] settle_ticks;
    } cfg_t;

    // level a phase puts on the pin it changes
    function automatic pin_t ph_level(input logic [PHASE_W-1:0] p);
        pin_t lvl;
        case (p)
            3'd0, 3'd2: lvl = PIN_HIGH;
            3'd4, 3'd6: lvl = PIN_LOW;
            default:    lvl = PIN_FLOAT;
        endcase
        return lvl;
    endfunction

    // even phases drive a pin, odd phases float one
    function automatic logic ph_drive(input logic [PHASE_W-1:0] p);
        return ~p[0];
    endfunction

    // 0: leading pin changes, 1: trailing pin changes
    function automatic logic ph_role(input logic [PHASE_W-1:0] p);
        return p[0] ^ p[1];
    endfunction

endpackage

>>> design/tpss_regs.sv
// configuration register file behind the apb-style port
module tpss_regs
    import tpss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DRIVE:  cfg_next.drive_ticks  = pwdata[DRIVE_W-1:0];
                REG_DEAD:   cfg_next.dead_ticks   = pwdata[DEAD_W-1:0];
                REG_SETTLE: cfg_next.settle_ticks = pwdata[SETTLE_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_ticks  <= DRIVE_RST;
            cfg_reg.dead_ticks   <= DEAD_RST;
            cfg_reg.settle_ticks <= SETTLE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DRIVE:  prdata = {{(32-DRIVE_W){1'b0}}, cfg_reg.drive_ticks};
            REG_DEAD:   prdata = {{(32-DEAD_W){1'b0}}, cfg_reg.dead_ticks};
            REG_SETTLE: prdata = {{(32-SETTLE_W){1'b0}}, cfg_reg.settle_ticks};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> design/two_pin_stepper_sequencer.sv
// two-pin stepper phase sequencer: stream front end, sequencer state and result register
// the result of a transaction is registered and is on m_tdata in the cycle after it is accepted
// throughput: one transaction per cycle; s_tready drops only while a result waits on m_tready
// the sequencer state and the result register are updated in the same cycle from the input
// reset: mode idle, both pins floating, timer and step count zero, registers at defaults
module two_pin_stepper_sequencer
    import tpss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // [0] direction, [8:1] step_count, [15:9] zero
    input  logic [1:0]        s_tuser,   // [1:0] action
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [1:0] pin_a, [3:2] pin_b, [4] busy_res, [5] rejected
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    cfg_t cfg;

    tpss_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mode_t               mode_reg,  mode_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic [TIMER_W-1:0]  timer_reg, timer_next;
    logic [STEPS_W-1:0]  steps_reg, steps_next;
    logic                dir_reg,   dir_next;
    pin_t                pin_a_reg, pin_a_next;
    pin_t                pin_b_reg, pin_b_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [7:0]          m_tdata_reg;

    logic                accept;
    logic [1:0]          action;
    logic                in_dir;
    logic [STEPS_W-1:0]  in_count;
    logic                busy;
    logic                rej;
    logic [TIMER_W-1:0]  timer_dec;
    logic [STEPS_W-1:0]  steps_dec;

    // phase apply and settle entry requests
    logic                ap_en;
    logic [PHASE_W-1:0]  ap_phase;
    logic                ap_dir;
    logic                st_en;
    logic                on_a;
    logic [DRIVE_W-1:0]  drive_len;
    logic [DEAD_W-1:0]   dead_len;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign action   = s_tuser;
    assign in_dir   = s_tdata[0];
    assign in_count = s_tdata[8:1];
    assign busy     = (mode_reg != MODE_IDLE);
    assign timer_dec = (timer_reg == '0) ? '0 : timer_reg - 1'b1;
    assign steps_dec = steps_reg - 1'b1;

    // zero length counts as one tick
    assign drive_len = (cfg.drive_ticks == '0) ? DRIVE_W'(1) : cfg.drive_ticks;
    assign dead_len  = (cfg.dead_ticks == '0) ? DEAD_W'(1) : cfg.dead_ticks;

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        timer_next = timer_reg;
        steps_next = steps_reg;
        dir_next   = dir_reg;
        pin_a_next = pin_a_reg;
        pin_b_next = pin_b_reg;
        rej        = 1'b0;
        ap_en      = 1'b0;
        ap_phase   = '0;
        ap_dir     = dir_reg;
        st_en      = 1'b0;
        on_a       = 1'b0;

        if (accept)
        begin
            case (action)
                ACT_START:
                begin
                    if (busy)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        dir_next   = in_dir;
                        steps_next = in_count;
                        phase_next = '0;
                        ap_dir     = in_dir;
                        if (in_count == '0)
                        begin
                            st_en = 1'b1;
                        end
                        else
                        begin
                            mode_next = MODE_STEP;
                            ap_en     = 1'b1;
                        end
                    end
                end
                ACT_RELEASE:
                begin
                    if (busy)
                    begin
                        rej = 1'b1;
                    end
                    else
                    begin
                        pin_a_next = PIN_FLOAT;
                        pin_b_next = PIN_FLOAT;
                    end
                end
                default:
                begin
                    // time tick, also the unused action code
                    unique case (mode_reg)
                        MODE_STEP:
                        begin
                            timer_next = timer_dec;
                            if (timer_dec == '0)
                            begin
                                phase_next = '0;
                                if (phase_reg == LAST_PHASE)
                                begin
                                    steps_next = steps_dec;
                                    if (steps_dec == '0)
                                        st_en = 1'b1;
                                    else
                                        ap_en = 1'b1;
                                end
                                else
                                begin
                                    phase_next = phase_reg + 1'b1;
                                    ap_phase   = phase_reg + 1'b1;
                                    ap_en      = 1'b1;
                                end
                            end
                        end
                        MODE_SETTLE:
                        begin
                            timer_next = timer_dec;
                            if (timer_dec == '0)
                                mode_next = MODE_IDLE;
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            endcase
        end

        if (ap_en)
        begin
            on_a = (ph_role(ap_phase) == 1'b0) == (ap_dir == 1'b0);
            if (on_a)
                pin_a_next = ph_level(ap_phase);
            else
                pin_b_next = ph_level(ap_phase);
            if (ph_drive(ap_phase))
                timer_next = drive_len;
            else
                timer_next = TIMER_W'(dead_len);
        end

        if (st_en)
        begin
            if (cfg.settle_ticks == '0)
            begin
                mode_next  = MODE_IDLE;
                timer_next = '0;
            end
            else
            begin
                mode_next  = MODE_SETTLE;
                timer_next = TIMER_W'(cfg.settle_ticks);
            end
        end

        if (accept)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            phase_reg    <= '0;
            timer_reg    <= '0;
            steps_reg    <= '0;
            dir_reg      <= 1'b0;
            pin_a_reg    <= PIN_FLOAT;
            pin_b_reg    <= PIN_FLOAT;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            phase_reg    <= phase_next;
            timer_reg    <= timer_next;
            steps_reg    <= steps_next;
            dir_reg      <= dir_next;
            pin_a_reg    <= pin_a_next;
            pin_b_reg    <= pin_b_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // result payload, loaded with the state after this transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {2'b00, rej, (mode_next != MODE_IDLE), pin_b_next, pin_a_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
